>>> rtl/trimmed_mean_lux_filter_top_defines.svh
// Assertion macros used by the trimmed-mean lux filter top level.
`ifndef TRIMMED_MEAN_LUX_FILTER_TOP_DEFINES_SVH
`define TRIMMED_MEAN_LUX_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define TMLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define TMLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tmlf_pkg.sv
// Types, constants and microcode ROM of the trimmed-mean lux filter.
`timescale 1ns / 1ps
package tmlf_pkg;

  // Field and datapath widths.
  localparam int unsigned SampleW = 16;
  localparam int unsigned LuxW    = 20;
  localparam int unsigned RunW    = 8;
  localparam int unsigned AW      = 23;
  localparam int unsigned StepW   = 4;

  // Register reset values and the saturation value of the zero-run count.
  localparam logic [LuxW-1:0] LuxCeilingReset = 20'd89999;
  localparam logic            ZeroWatchReset  = 1'b1;
  localparam logic [RunW-1:0] ZeroLimitReset  = 8'd25;
  localparam logic [RunW-1:0] RunMax          = 8'd255;

  // Scale factors and the fixed divisors with their reciprocals (2^AW / d).
  localparam logic [AW:0] Scale10    = 24'd10;
  localparam logic [AW:0] Scale139   = 24'd139;
  localparam logic [AW:0] Div12      = 24'd12;
  localparam logic [AW:0] Div13      = 24'd13;
  localparam logic [AW:0] Recip12    = (AW+1)'((1 << AW) / 12);
  localparam logic [AW:0] Recip13    = (AW+1)'((1 << AW) / 13);

  // Program addresses used as jump targets.
  localparam logic [StepW-1:0] StepWait = 4'd0;
  localparam logic [StepW-1:0] StepWalk = 4'd1;
  localparam logic [StepW-1:0] StepOut  = 4'd14;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_LUX_CEILING = 2'd0,
    REG_ZERO_WATCH  = 2'd1,
    REG_ZERO_LIMIT  = 2'd2
  } reg_e;

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_WALK,
    OP_TRIM,
    OP_SCALE,
    OP_RECIP,
    OP_BACK,
    OP_FIX,
    OP_OUT
  } op_e;

  // Divisor selection for the reciprocal steps.
  typedef enum logic [1:0] {
    DSEL_TRIM,
    DSEL_12,
    DSEL_13
  } dsel_e;

  // Scale factor selection.
  typedef enum logic {
    SSEL_10,
    SSEL_139
  } ssel_e;

  // Sequencing conditions.
  typedef enum logic [1:0] {
    COND_NONE,
    COND_GO,
    COND_MORE,
    COND_FREE
  } cond_e;

  typedef struct packed {
    op_e              op;
    dsel_e            dsel;
    ssel_e            ssel;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ucode_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic go;
    logic more;
    logic free;
  } status_t;

  typedef struct packed {
    logic [SampleW-1:0] raw_sample;
    logic               read_ok;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic [LuxW-1:0] lux;
    logic            reset_request;
  } out_item_t;

  typedef struct packed {
    logic [LuxW-1:0] lux_ceiling;
    logic            zero_watch_enable;
    logic [RunW-1:0] zero_run_limit;
  } cfg_t;

  function automatic ucode_t make_word(op_e op, dsel_e dsel, ssel_e ssel, cond_e cond,
                                       logic [StepW-1:0] target);
    ucode_t w;
    w.op     = op;
    w.dsel   = dsel;
    w.ssel   = ssel;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Microprogram: walk the ring, trim, divide, then twice scale and divide, clamp and deliver.
  function automatic ucode_t ucode_rom(logic [StepW-1:0] step);
    ucode_t w;
    case (step)
      4'd0:    w = make_word(OP_WAIT,  DSEL_TRIM, SSEL_10,  COND_GO,   StepWalk);
      4'd1:    w = make_word(OP_WALK,  DSEL_TRIM, SSEL_10,  COND_MORE, StepWalk);
      4'd2:    w = make_word(OP_TRIM,  DSEL_TRIM, SSEL_10,  COND_NONE, StepWait);
      4'd3:    w = make_word(OP_RECIP, DSEL_TRIM, SSEL_10,  COND_NONE, StepWait);
      4'd4:    w = make_word(OP_BACK,  DSEL_TRIM, SSEL_10,  COND_NONE, StepWait);
      4'd5:    w = make_word(OP_FIX,   DSEL_TRIM, SSEL_10,  COND_NONE, StepWait);
      4'd6:    w = make_word(OP_SCALE, DSEL_12,   SSEL_10,  COND_NONE, StepWait);
      4'd7:    w = make_word(OP_RECIP, DSEL_12,   SSEL_10,  COND_NONE, StepWait);
      4'd8:    w = make_word(OP_BACK,  DSEL_12,   SSEL_10,  COND_NONE, StepWait);
      4'd9:    w = make_word(OP_FIX,   DSEL_12,   SSEL_10,  COND_NONE, StepWait);
      4'd10:   w = make_word(OP_SCALE, DSEL_13,   SSEL_139, COND_NONE, StepWait);
      4'd11:   w = make_word(OP_RECIP, DSEL_13,   SSEL_139, COND_NONE, StepWait);
      4'd12:   w = make_word(OP_BACK,  DSEL_13,   SSEL_139, COND_NONE, StepWait);
      4'd13:   w = make_word(OP_FIX,   DSEL_13,   SSEL_139, COND_NONE, StepWait);
      4'd14:   w = make_word(OP_OUT,   DSEL_13,   SSEL_139, COND_FREE, StepWait);
      default: w = make_word(OP_WAIT,  DSEL_TRIM, SSEL_10,  COND_FREE, StepWait);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/tmlf_sequencer.sv
// Step counter and microcode ROM that drive the filter datapath.
`timescale 1ns / 1ps
module tmlf_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tmlf_pkg::status_t status_i,
  output tmlf_pkg::ucode_t  ctrl_o
);
  import tmlf_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  ucode_t           word;

  // Control word of the current step.
  always_comb begin
    word   = ucode_rom(step_q);
    ctrl_o = word;
  end

  // Next step: advance, hold or jump as the word's condition says.
  always_comb begin
    step_d = step_q + StepW'(1);
    case (word.cond)
      COND_NONE: step_d = step_q + StepW'(1);
      COND_GO:   step_d = status_i.go ? step_q + StepW'(1) : step_q;
      COND_MORE: step_d = status_i.more ? word.target : step_q + StepW'(1);
      COND_FREE: step_d = status_i.free ? word.target : step_q;
      default:   step_d = StepWait;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepWait;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> rtl/tmlf_datapath.sv
// Sample ring, accumulator, shared multiplier, zero-run watch and output register.
`timescale 1ns / 1ps
module tmlf_datapath #(
  parameter int unsigned RING_DEPTH = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmlf_pkg::ucode_t    ctrl_i,
  input  tmlf_pkg::cfg_t      cfg_i,
  output tmlf_pkg::status_t   status_o,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tmlf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmlf_pkg::out_item_t out_data_o
);
  import tmlf_pkg::*;

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam int unsigned AccW = SampleW + $clog2(RING_DEPTH);
  localparam logic [AW:0] DivTrim   = (AW+1)'(RING_DEPTH - 2);
  localparam logic [AW:0] RecipTrim = (AW+1)'((1 << AW) / (RING_DEPTH - 2));

  logic [SampleW-1:0] ring_q [RING_DEPTH];
  logic               filled_q;
  logic [IdxW-1:0]    slot_q, slot_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [SampleW-1:0] hi_q, hi_d, lo_q, lo_d;
  logic [AW-1:0]      a_q, a_d, q_q, q_d, t_q, t_d;
  logic [RunW-1:0]    run_q, run_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               accept, good, more, free, fire;
  logic [SampleW-1:0] rd;
  logic [AW-1:0]      mul_a, rem;
  logic [AW:0]        mul_b, dval, recip, scale;
  logic [2*AW:0]      prod;
  logic [LuxW-1:0]    lux;
  logic [RunW-1:0]    run_inc;
  logic               req;

  // Input handshake: new transactions only while the program waits.
  assign in_ready_o = (ctrl_i.op == OP_WAIT);
  assign accept     = in_valid_i && in_ready_o;
  assign good       = accept && in_data_i.read_ok;

  assign rd    = ring_q[idx_q];
  assign more  = (idx_q != IdxW'(RING_DEPTH - 1));
  assign free  = !out_valid_q || out_ready_i;
  assign fire  = (ctrl_i.op == OP_OUT) && free;

  assign status_o.go   = good;
  assign status_o.more = more;
  assign status_o.free = free;

  // Constant selection for the shared multiplier.
  always_comb begin
    case (ctrl_i.dsel)
      DSEL_TRIM: begin
        dval  = DivTrim;
        recip = RecipTrim;
      end
      DSEL_12: begin
        dval  = Div12;
        recip = Recip12;
      end
      DSEL_13: begin
        dval  = Div13;
        recip = Recip13;
      end
      default: begin
        dval  = DivTrim;
        recip = RecipTrim;
      end
    endcase
    scale = (ctrl_i.ssel == SSEL_139) ? Scale139 : Scale10;
  end

  // Multiplier operands: reciprocal estimate, back-multiply or scale.
  always_comb begin
    case (ctrl_i.op)
      OP_RECIP: begin
        mul_a = a_q;
        mul_b = recip;
      end
      OP_BACK: begin
        mul_a = q_q;
        mul_b = dval;
      end
      default: begin
        mul_a = a_q;
        mul_b = scale;
      end
    endcase
    prod = (2*AW+1)'(mul_a) * (2*AW+1)'(mul_b);
  end

  assign rem = a_q - t_q;

  // Datapath register updates for each operation.
  always_comb begin
    acc_d = acc_q;
    hi_d  = hi_q;
    lo_d  = lo_q;
    a_d   = a_q;
    q_d   = q_q;
    t_d   = t_q;
    idx_d = idx_q;
    case (ctrl_i.op)
      OP_WAIT: idx_d = '0;
      OP_WALK: begin
        idx_d = more ? idx_q + IdxW'(1) : '0;
        if (idx_q == '0) begin
          acc_d = AccW'(rd);
          hi_d  = rd;
          lo_d  = rd;
        end else begin
          acc_d = acc_q + AccW'(rd);
          hi_d  = (rd > hi_q) ? rd : hi_q;
          lo_d  = (rd < lo_q) ? rd : lo_q;
        end
      end
      OP_TRIM:  a_d = AW'(acc_q - AccW'(hi_q) - AccW'(lo_q));
      OP_SCALE: a_d = prod[AW-1:0];
      OP_RECIP: q_d = prod[2*AW-1:AW];
      OP_BACK:  t_d = prod[AW-1:0];
      OP_FIX:   a_d = ({1'b0, rem} >= dval) ? q_q + AW'(1) : q_q;
      default:  a_d = a_q;
    endcase
  end

  // Clamp and zero-run watch for the result being delivered.
  always_comb begin
    lux     = (a_q > AW'(cfg_i.lux_ceiling)) ? cfg_i.lux_ceiling : a_q[LuxW-1:0];
    run_inc = (lux == '0) ? ((run_q == RunMax) ? run_q : run_q + RunW'(1)) : '0;
    req     = 1'b0;
    run_d   = run_q;
    if (fire) begin
      if (cfg_i.zero_watch_enable) begin
        if (run_inc > cfg_i.zero_run_limit) begin
          run_d = '0;
          req   = 1'b1;
        end else begin
          run_d = run_inc;
        end
      end else begin
        run_d = '0;
      end
    end
  end

  // Output register and write slot.
  always_comb begin
    out_valid_d       = out_valid_q && !out_ready_i;
    out_d             = out_q;
    slot_d            = slot_q;
    if (fire) begin
      out_valid_d       = 1'b1;
      out_d.lux           = lux;
      out_d.reset_request = req;
    end
    if (good) begin
      slot_d = (slot_q == IdxW'(RING_DEPTH - 1)) ? '0 : slot_q + IdxW'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q    <= 1'b0;
      slot_q      <= '0;
      idx_q       <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      idx_q       <= idx_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      if (good) begin
        filled_q <= 1'b1;
      end
    end
  end

  // Sample ring: a restart or the first good sample fills every slot.
  always_ff @(posedge clk_i) begin
    if (good) begin
      if (in_data_i.restart || !filled_q) begin
        for (int k = 0; k < RING_DEPTH; k++) begin
          ring_q[k] <= in_data_i.raw_sample;
        end
      end else begin
        ring_q[slot_q] <= in_data_i.raw_sample;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    a_q   <= a_d;
    q_q   <= q_d;
    t_q   <= t_d;
    out_q <= out_d;
  end

endmodule

>>> rtl/trimmed_mean_lux_filter_top.sv
// Top level of the trimmed-mean lux filter with its APB register block.
// A good sample starts the program: the ring walk through one read port, twelve arithmetic
// steps around the shared multiplier, the output step and the return to the wait step; no
// new sample is taken before the program is back in its wait step.
// A failed read leaves the program waiting; a stalled result holds the program in its output step.
// Reset: rst_ni sets the registers to their defaults, marks the ring empty, clears the run count.
`timescale 1ns / 1ps
`include "trimmed_mean_lux_filter_top_defines.svh"
module trimmed_mean_lux_filter_top #(
  parameter int unsigned RING_DEPTH = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tmlf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmlf_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tmlf_pkg::*;

  cfg_t    cfg_q;
  ucode_t  ctrl;
  status_t status;
  reg_e    reg_idx;
  logic    wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lux_ceiling       <= LuxCeilingReset;
      cfg_q.zero_watch_enable <= ZeroWatchReset;
      cfg_q.zero_run_limit    <= ZeroLimitReset;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LUX_CEILING: cfg_q.lux_ceiling       <= pwdata[LuxW-1:0];
        REG_ZERO_WATCH:  cfg_q.zero_watch_enable <= pwdata[0];
        REG_ZERO_LIMIT:  cfg_q.zero_run_limit    <= pwdata[RunW-1:0];
        default:         cfg_q                   <= cfg_q;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_idx)
      REG_LUX_CEILING: prdata = 32'(cfg_q.lux_ceiling);
      REG_ZERO_WATCH:  prdata = 32'(cfg_q.zero_watch_enable);
      REG_ZERO_LIMIT:  prdata = 32'(cfg_q.zero_run_limit);
      default:         prdata = '0;
    endcase
  end

  tmlf_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  tmlf_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg_q),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A failed read is dropped at once; a good one keeps the block busy.
  `TMLF_ASSERT_NEXT(a_fail_stays_ready, in_valid_i && in_ready_o && !in_data_i.read_ok, in_ready_o, "failed read left the block busy")
  `TMLF_ASSERT_NEXT(a_good_goes_busy, in_valid_i && in_ready_o && in_data_i.read_ok, !in_ready_o, "good sample did not start the program")
  // A reset request comes only with a zero result, and no result exceeds the ceiling.
  `TMLF_ASSERT_NOW(a_req_on_zero, out_valid_o && out_data_o.reset_request, out_data_o.lux == '0, "reset request on a non-zero result")
  `TMLF_ASSERT_NOW(a_lux_clamped, out_valid_o, out_data_o.lux <= cfg_q.lux_ceiling, "result above the lux ceiling")

endmodule

>>> verif/trimmed_mean_lux_filter_top_test.sv
// Self-checking testbench for the trimmed-mean lux filter top level.
`timescale 1ns / 1ps
module trimmed_mean_lux_filter_top_test;
  import tmlf_pkg::*;

  localparam int unsigned RING_DEPTH  = 10;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned DrainCycles = RING_DEPTH + 20;
  localparam int unsigned CycleLimit  = 500_000;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned LuxMax      = 583928;

  // Clock, reset and block ports; the driven inputs start at known values from time zero.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus and checking state.
  in_item_t    sample_queue[$];
  out_item_t   lux_expected[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_gap         = 0;
  int unsigned rx_gap         = 0;
  logic        tx_calm        = 1'b0;
  logic        rx_calm        = 1'b0;
  logic        rx_hold        = 1'b0;
  logic        pressure_go    = 1'b0;

  // Shadow copy of the filter state and its registers.
  logic [SampleW-1:0] shadow_ring[RING_DEPTH];
  logic               shadow_filled = 1'b0;
  int unsigned        shadow_slot   = 0;
  int unsigned        shadow_run    = 0;
  logic [LuxW-1:0]    cfg_ceiling   = LuxCeilingReset;
  logic               cfg_watch     = ZeroWatchReset;
  logic [RunW-1:0]    cfg_limit     = ZeroLimitReset;

  trimmed_mean_lux_filter_top #(
    .RING_DEPTH(RING_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the lux result of one accepted sample and queues it if the read was good.
  function automatic void predict_lux(in_item_t item);
    int unsigned slot;
    int unsigned total;
    int unsigned hi;
    int unsigned lo;
    int unsigned mean;
    int unsigned lux;
    logic        req;
    out_item_t   res;
    if (!item.read_ok) begin
      return;
    end
    slot        = (shadow_slot >= RING_DEPTH) ? 0 : shadow_slot;
    shadow_slot = (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;
    if (item.restart || !shadow_filled) begin
      for (int k = 0; k < RING_DEPTH; k++) shadow_ring[k] = item.raw_sample;
      shadow_filled = 1'b1;
    end else begin
      shadow_ring[slot] = item.raw_sample;
    end
    total = 0;
    hi    = 32'(shadow_ring[0]);
    lo    = 32'(shadow_ring[0]);
    for (int k = 0; k < RING_DEPTH; k++) begin
      total += 32'(shadow_ring[k]);
      if (32'(shadow_ring[k]) > hi) hi = 32'(shadow_ring[k]);
      if (32'(shadow_ring[k]) < lo) lo = 32'(shadow_ring[k]);
    end
    mean = ((total - (hi + lo)) / (RING_DEPTH - 2)) & 32'hFFFF;
    lux  = (mean * 10) / 12;
    lux  = (lux * 139) / 13;
    if (lux > 32'(cfg_ceiling)) lux = 32'(cfg_ceiling);
    req = 1'b0;
    if (cfg_watch) begin
      if (lux == 0) begin
        if (shadow_run < 32'(RunMax)) shadow_run++;
      end else begin
        shadow_run = 0;
      end
      if (shadow_run > 32'(cfg_limit)) begin
        shadow_run = 0;
        req        = 1'b1;
      end
    end else begin
      shadow_run = 0;
    end
    res.lux           = lux[LuxW-1:0];
    res.reset_request = req;
    lux_expected.push_back(res);
  endfunction

  // Sender: offers queued samples with a random gap after each transaction unless tx_calm is set.
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) begin
        predict_lux(in_data_i);
        tx_gap = tx_calm ? 0 : $urandom_range(0, 18);
      end
      if (tx_gap == 0 && sample_queue.size() != 0) begin
        in_data_i  <= sample_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
        if (tx_gap != 0) tx_gap--;
      end
    end
  end

  // Receiver: checks each result transaction, then stalls for a random spell unless rx_calm is set.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (lux_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("lux_check: unexpected result lux %0d req %0b",
                     out_data_o.lux, out_data_o.reset_request);
          end
        end else if (out_data_o.lux != lux_expected[0].lux ||
                     out_data_o.reset_request != lux_expected[0].reset_request) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("lux_check: expected lux %0d req %0b, got lux %0d req %0b",
                     lux_expected[0].lux, lux_expected[0].reset_request,
                     out_data_o.lux, out_data_o.reset_request);
          end
          void'(lux_expected.pop_front());
        end else begin
          void'(lux_expected.pop_front());
        end
        rx_gap = rx_calm ? 0 : $urandom_range(0, 18);
      end
      if (rx_gap != 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !rx_hold;
      end
    end
  end

  // Long receiver hold-off so that the filter backs up and stalls its input.
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("trimmed_mean_lux_filter_top: mismatch");
      $finish;
    end
  end

  // Register write over the APB port; the shadow copy follows at the access edge.
  task automatic write_reg(reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LUX_CEILING: cfg_ceiling = value[LuxW-1:0];
      REG_ZERO_WATCH:  cfg_watch   = value[0];
      REG_ZERO_LIMIT:  cfg_limit   = value[RunW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned ceiling, logic watch, int unsigned limit);
    write_reg(REG_LUX_CEILING, ceiling);
    write_reg(REG_ZERO_WATCH, {31'd0, watch});
    write_reg(REG_ZERO_LIMIT, limit);
    @(negedge clk_i);
  endtask

  task automatic queue_item(int unsigned sample, logic ok, logic restart);
    in_item_t item;
    item.raw_sample = sample[SampleW-1:0];
    item.read_ok    = ok;
    item.restart    = restart;
    sample_queue.push_back(item);
  endtask

  // Mostly good reads with random content, broken up by runs of near-zero samples.
  task automatic queue_random(int unsigned count);
    int unsigned burst;
    int unsigned sample;
    logic        restart;
    burst = 0;
    for (int unsigned n = 0; n < count; n++) begin
      restart = ($urandom_range(0, 24) == 0);
      if (burst == 0 && $urandom_range(0, 15) == 0) begin
        burst   = $urandom_range(4, 40);
        restart = 1'($urandom_range(0, 1));
      end
      if (burst != 0) begin
        sample = $urandom_range(0, 1);
        burst--;
      end else begin
        case ($urandom_range(0, 3))
          0:       sample = $urandom_range(0, 65535);
          1:       sample = $urandom_range(0, 15);
          2:       sample = $urandom_range(65500, 65535);
          default: sample = $urandom_range(0, 4000);
        endcase
      end
      queue_item(sample, $urandom_range(0, 9) != 0, restart);
    end
  endtask

  // Waits until every expected result has arrived and the pipeline is empty.
  task automatic settle();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || lux_expected.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned ceil_pick;
    logic        watch_pick;
    int unsigned limit_pick;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);

    // Default registers: failed reads, ring fill without restart, extremes, ceiling edge.
    tx_calm <= 1'b0;
    rx_calm <= 1'b0;
    queue_item(16'h1234, 1'b0, 1'b0);
    queue_item(16'hFFFF, 1'b1, 1'b0);
    queue_item(16'h0000, 1'b1, 1'b0);
    queue_item(16'h0000, 1'b0, 1'b1);
    queue_item(16'h0000, 1'b1, 1'b1);
    queue_item(16'h0001, 1'b1, 1'b0);
    queue_item(16'hFFFF, 1'b1, 1'b0);
    queue_item(16'hFFFF, 1'b1, 1'b0);
    queue_item(16'h0001, 1'b1, 1'b1);
    queue_item(16'h0002, 1'b1, 1'b1);
    queue_item(16'h000C, 1'b1, 1'b1);
    queue_item(16'h8000, 1'b1, 1'b0);
    queue_item(16'h7FFF, 1'b1, 1'b0);
    queue_item(16'h5555, 1'b1, 1'b0);
    queue_item(16'hAAAA, 1'b1, 1'b0);
    queue_item(16'h0100, 1'b0, 1'b0);
    queue_item(9000, 1'b1, 1'b1);
    queue_item(10101, 1'b1, 1'b1);
    queue_item(10102, 1'b1, 1'b1);
    settle();

    // Zero ceiling: every result is zero and the watch fires often.
    configure(0, 1'b1, 3);
    for (int n = 0; n < 10; n++) queue_item($urandom_range(0, 65535), 1'b1, n % 3 == 0);
    settle();

    // Top ceiling with the watch off: zeros never raise a request.
    configure(LuxMax, 1'b0, 0);
    queue_item(16'hFFFF, 1'b1, 1'b1);
    queue_item(16'h0000, 1'b1, 1'b1);
    queue_item(16'h0000, 1'b1, 1'b0);
    queue_item(16'h0001, 1'b1, 1'b0);
    queue_item(300, 1'b1, 1'b0);
    settle();

    // Random phases over a spread of register settings.
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 4))
        0:       ceil_pick = 0;
        1:       ceil_pick = LuxMax;
        2:       ceil_pick = 32'(LuxCeilingReset);
        3:       ceil_pick = $urandom_range(0, 2000);
        default: ceil_pick = $urandom_range(0, LuxMax);
      endcase
      watch_pick = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       limit_pick = 0;
        1:       limit_pick = 32'(RunMax);
        default: limit_pick = $urandom_range(0, 40);
      endcase
      // A saturated zero run followed by a limit just below it.
      if (p == 4) begin
        limit_pick = 32'(RunMax);
        watch_pick = 1'b1;
      end else if (p == 5) begin
        limit_pick = 32'(RunMax) - 1;
        watch_pick = 1'b1;
      end
      tx_calm <= (p == 0) || (p == 2);
      rx_calm <= (p == 0);
      configure(ceil_pick, watch_pick, limit_pick);
      if (p == 2) pressure_go <= 1'b1;
      if (p == 5) begin
        for (int n = 0; n < 5; n++) queue_item(0, 1'b1, 1'b0);
      end
      queue_random(170);
      if (p == 4) begin
        queue_item(0, 1'b1, 1'b1);
        for (int n = 0; n < 299; n++) queue_item($urandom_range(0, 1), 1'b1, 1'b0);
      end
      settle();
    end

    if (mismatch_count == 0 && lux_expected.size() == 0) begin
      $display("trimmed_mean_lux_filter_top: match");
    end else begin
      $display("trimmed_mean_lux_filter_top: mismatch");
    end
    $finish;
  end

endmodule
